### sv/padded_interval_merger_defines.svh
// assertion macros shared by the interval merger modules
`ifndef PADDED_INTERVAL_MERGER_DEFINES_SVH
`define PADDED_INTERVAL_MERGER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PIM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PIM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  `PIM_ASSERT(lbl, clk, rst, !(expr), msg)
`else
`define PIM_ASSERT(lbl, clk, rst, prop, msg)
`define PIM_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### sv/pim_pkg.sv
// shared types and constants of the padded interval merger
package pim_pkg;

  localparam int TW     = 43;  // signed time width
  localparam int IW     = 40;  // input tick width
  localparam int CW     = 32;  // config register width
  localparam int QDEPTH = 4;   // front to back queue depth
  localparam int QPW    = $clog2(QDEPTH);

  typedef logic signed [TW-1:0] tick_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_SUB      = 3'd0,
    KIND_LEAD     = 3'd1,
    KIND_TRAIL    = 3'd2,
    KIND_DIALOGUE = 3'd3,
    KIND_GAP      = 3'd4
  } pim_kind_t;

  // config register indexes
  typedef enum logic [1:0] {
    REG_LEFT_PAD    = 2'd0,
    REG_RIGHT_PAD   = 2'd1,
    REG_TIME_OFFSET = 2'd2,
    REG_MIN_GAP     = 2'd3
  } pim_reg_t;

  // output sequencer phases
  typedef enum logic [2:0] {
    PH_SUB,
    PH_LEAD,
    PH_TRAIL,
    PH_MID,
    PH_FLUSH
  } pim_phase_t;

  // settings seen by the front part
  typedef struct packed {
    logic [CW-1:0]        left_pad;
    logic [CW-1:0]        right_pad;
    logic signed [CW-1:0] time_offset;
    logic [CW:0]          lead_gap;  // left_pad + min_gap
  } pim_cfg_t;

  // one classified item, as queued for the back part
  typedef struct packed {
    tick_t     s;
    tick_t     e;
    tick_t     ns;
    tick_t     ne;
    logic      mid_valid;
    pim_kind_t mid_kind;
    tick_t     mid_b;
    tick_t     mid_f;
    logic      fl_valid;
    tick_t     fl_b;
    tick_t     fl_f;
  } pim_cmd_t;

endpackage

### sv/pim_front.sv
// front part: shifts and pads each item, folds it into the span, queues a command
`include "padded_interval_merger_defines.svh"
module pim_front import pim_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  pim_cfg_t              cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IW-1:0]         item_start,
  input  logic [IW-1:0]         item_end,
  input  logic                  final_item,
  input  logic                  q_full,
  output logic                  q_push,
  output pim_cmd_t              q_cmd
);

  // stage 1: shifted interval
  logic  v1;
  tick_t s1_s, s1_e;
  logic  s1_last;
  // stage 2: padded interval and close cut point
  logic  v2;
  tick_t s2_s, s2_e, s2_ns, s2_ne, s2_cut;
  logic  s2_last;
  // running span
  tick_t span_lo, span_hi;
  logic  seen_first;

  logic  ld1, ld2;
  tick_t offs;

  assign q_push   = v2 && !q_full;
  assign ld2      = !v2 || q_push;
  assign ld1      = !v1 || ld2;
  assign in_stall = v1 && !ld2;
  assign offs     = {{(TW-CW){cfg.time_offset[CW-1]}}, cfg.time_offset};

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= in_valid;
    end
    if (ld1 && in_valid) begin
      s1_s    <= tick_t'({{(TW-IW){1'b0}}, item_start}) + offs;
      s1_e    <= tick_t'({{(TW-IW){1'b0}}, item_end}) + offs;
      s1_last <= final_item;
    end
  end

  function automatic logic s2_last_in(logic v, logic l);
    return v & l;
  endfunction

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
    if (ld2 && v1) begin
      s2_s    <= s1_s;
      s2_e    <= s1_e;
      s2_ns   <= s1_s - tick_t'({{(TW-CW){1'b0}}, cfg.left_pad});
      s2_ne   <= s1_e + tick_t'({{(TW-CW){1'b0}}, cfg.right_pad});
      s2_cut  <= s1_s - tick_t'({{(TW-CW-1){1'b0}}, cfg.lead_gap});
      s2_last <= s2_last_in(v1, s1_last);
    end
  end

  // classification against the running span
  logic  ns_lt_ne, lo_lt_hi, lo_lt_ne, do_close;
  logic  post_ok;
  tick_t lo_next, hi_next;

  assign ns_lt_ne = s2_ns < s2_ne;
  assign lo_lt_hi = span_lo < span_hi;
  assign lo_lt_ne = span_lo < s2_ne;
  // span end plus min gap reaches the padded start
  assign do_close = span_hi <= s2_cut;

  always_comb begin
    lo_next           = span_lo;
    hi_next           = span_hi;
    post_ok           = lo_lt_hi;
    q_cmd.s           = s2_s;
    q_cmd.e           = s2_e;
    q_cmd.ns          = s2_ns;
    q_cmd.ne          = s2_ne;
    q_cmd.mid_valid   = 1'b0;
    q_cmd.mid_kind    = KIND_GAP;
    q_cmd.mid_b       = span_hi;
    q_cmd.mid_f       = s2_ns;
    if (!seen_first) begin
      // first item of a run opens the span as is
      lo_next  = s2_ns;
      hi_next  = s2_ne;
      post_ok  = ns_lt_ne;
    end else if (ns_lt_ne) begin
      hi_next  = s2_ne;
      if (do_close) begin
        // gap wide enough: close the span, open a new one
        q_cmd.mid_valid = lo_lt_hi;
        q_cmd.mid_kind  = KIND_DIALOGUE;
        q_cmd.mid_b     = span_lo;
        q_cmd.mid_f     = span_hi;
        lo_next         = s2_ns;
        post_ok         = 1'b1;
      end else if (lo_lt_hi) begin
        // merge and report the gap
        q_cmd.mid_valid = 1'b1;
        post_ok         = lo_lt_ne;
      end else begin
        // empty span: its begin moves up
        lo_next = s2_ns;
        post_ok = 1'b1;
      end
    end
    q_cmd.fl_valid = s2_last && post_ok;
    q_cmd.fl_b     = lo_next;
    q_cmd.fl_f     = hi_next;
  end

  // span state update as the command is queued
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first <= 1'b0;
      span_lo    <= '0;
      span_hi    <= '0;
    end else if (q_push) begin
      if (s2_last) begin
        seen_first <= 1'b0;
        span_lo    <= '0;
        span_hi    <= '0;
      end else begin
        seen_first <= 1'b1;
        span_lo    <= lo_next;
        span_hi    <= hi_next;
      end
    end
  end

  // checks
  `PIM_ASSERT(a_flush_clears, clk, rst, q_push && s2_last |=> !seen_first && span_hi == 0, "flush left span state")
  `PIM_ASSERT(a_held_when_full, clk, rst, v2 && q_full |=> v2, "item lost while queue full")
  `PIM_ASSERT(a_no_stall_empty, clk, rst, !v1 |-> !in_stall, "stall with empty front")

endmodule

### sv/pim_queue.sv
// short command queue between front and back parts
`include "padded_interval_merger_defines.svh"
module pim_queue import pim_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pim_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output pim_cmd_t head,
  output logic     empty
);

  pim_cmd_t       entries [QDEPTH];
  logic [QPW-1:0] wr_ptr, rd_ptr;
  logic [QPW:0]   count;

  assign full  = count == (QPW+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // checks
  `PIM_ASSERT_NEVER(a_overflow, clk, rst, push && full, "push into full queue")
  `PIM_ASSERT_NEVER(a_underflow, clk, rst, pop && empty, "pop from empty queue")
  `PIM_ASSERT(a_count_step, clk, rst, push && !pop |=> count == $past(count) + 1'b1, "count slip")

endmodule

### sv/pim_back.sv
// back part: plays out the results of each queued command, one per cycle unless the output stalls
`include "padded_interval_merger_defines.svh"
module pim_back import pim_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pim_cmd_t    head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output tick_t       span_begin,
  output tick_t       span_finish,
  output logic        run_done
);

  pim_phase_t phase, phase_next;
  pim_kind_t  res_kind;
  tick_t      res_b, res_f;
  logic       res_last;
  logic       load;

  assign load  = !q_empty && (!out_valid || !out_stall);
  assign q_pop = load && res_last;

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SUB;
    end else if (load) begin
      phase <= phase_next;
    end
  end

  // result selection and next phase
  always_comb begin
    res_kind   = KIND_SUB;
    res_b      = head.s;
    res_f      = head.e;
    res_last   = 1'b0;
    phase_next = phase;
    case (phase)
      PH_SUB: begin
        phase_next = PH_LEAD;
      end
      PH_LEAD: begin
        res_kind   = KIND_LEAD;
        res_b      = head.ns;
        res_f      = head.s;
        phase_next = PH_TRAIL;
      end
      PH_TRAIL: begin
        res_kind = KIND_TRAIL;
        res_b    = head.e;
        res_f    = head.ne;
        if (head.mid_valid) begin
          phase_next = PH_MID;
        end else if (head.fl_valid) begin
          phase_next = PH_FLUSH;
        end else begin
          res_last   = 1'b1;
          phase_next = PH_SUB;
        end
      end
      PH_MID: begin
        res_kind = head.mid_kind;
        res_b    = head.mid_b;
        res_f    = head.mid_f;
        if (head.fl_valid) begin
          phase_next = PH_FLUSH;
        end else begin
          res_last   = 1'b1;
          phase_next = PH_SUB;
        end
      end
      PH_FLUSH: begin
        res_kind   = KIND_DIALOGUE;
        res_b      = head.fl_b;
        res_f      = head.fl_f;
        res_last   = 1'b1;
        phase_next = PH_SUB;
      end
      default: begin
        phase_next = PH_SUB;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      kind        <= res_kind;
      span_begin  <= res_b;
      span_finish <= res_f;
      run_done    <= res_last;
    end
  end

  // checks
  `PIM_ASSERT(a_mid_present, clk, rst, load && phase == PH_MID |-> head.mid_valid, "mid result without cause")
  `PIM_ASSERT(a_flush_present, clk, rst, load && phase == PH_FLUSH |-> head.fl_valid, "flush result without cause")
  `PIM_ASSERT(a_pop_resets_phase, clk, rst, q_pop |=> phase == PH_SUB, "phase not rewound after pop")

endmodule

### sv/padded_interval_merger.sv
// top level of the padded interval merger: config registers and part wiring
//
// Each accepted item gives three to five results (subtitle, lead pad, trail
// pad, then a dialogue span or a gap, then the flushed span on a final item),
// delivered one per cycle while the output is not stalled, in the order set by
// the output sequencer in the back part. An accepted item passes the stage 1
// and stage 2 registers, then enters the four-entry command queue. The front
// keeps taking items while the back still plays out earlier ones, until the
// queue is full. The config port is always ready; write it only while the
// block is idle.
module padded_interval_merger import pim_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CW-1:0]         cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IW-1:0]         item_start,
  input  logic [IW-1:0]         item_end,
  input  logic                  final_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            kind,
  output logic signed [TW-1:0]  span_begin,
  output logic signed [TW-1:0]  span_finish,
  output logic                  run_done
);

  logic [CW-1:0]        left_pad, right_pad, min_gap;
  logic signed [CW-1:0] time_offset;
  logic [CW:0]          lead_gap;
  pim_cfg_t             cfg;

  logic     q_push, q_full, q_pop, q_empty;
  pim_cmd_t q_cmd, q_head;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pad    <= '0;
      right_pad   <= '0;
      time_offset <= '0;
      min_gap     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (pim_reg_t'(cfg_index))
        REG_LEFT_PAD:    left_pad    <= cfg_data;
        REG_RIGHT_PAD:   right_pad   <= cfg_data;
        REG_TIME_OFFSET: time_offset <= cfg_data;
        REG_MIN_GAP:     min_gap     <= cfg_data;
        default: ;
      endcase
    end
  end

  // lead pad plus gap, for the close cut point
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_gap <= '0;
    end else begin
      lead_gap <= {1'b0, left_pad} + {1'b0, min_gap};
    end
  end

  assign cfg.left_pad    = left_pad;
  assign cfg.right_pad   = right_pad;
  assign cfg.time_offset = time_offset;
  assign cfg.lead_gap    = lead_gap;

  pim_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_start (item_start),
    .item_end   (item_end),
    .final_item (final_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  pim_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  pim_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .span_begin  (span_begin),
    .span_finish (span_finish),
    .run_done    (run_done)
  );

endmodule
